// ----- rtl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, control word layout and the microcode program of the RC4 core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned KeyLenW     = 9;
  localparam int unsigned SboxDepth   = 256;
  localparam int unsigned KeyDepth    = 256;
  localparam int unsigned MaxKeyLenDef = 256;
  localparam int unsigned StepW       = 4;

  // request type
  localparam logic ReqKey  = 1'b0;
  localparam logic ReqData = 1'b1;

  // memory operation
  localparam logic [1:0] MemNone = 2'd0;
  localparam logic [1:0] MemRd   = 2'd1;
  localparam logic [1:0] MemWr   = 2'd2;

  // s-box address select
  localparam logic [2:0] AddrN     = 3'd0;
  localparam logic [2:0] AddrI     = 3'd1;
  localparam logic [2:0] AddrJ     = 3'd2;
  localparam logic [2:0] AddrJNext = 3'd3;
  localparam logic [2:0] AddrSum   = 3'd4;

  // s-box write data select
  localparam logic [1:0] WdN     = 2'd0;
  localparam logic [1:0] WdRdata = 2'd1;
  localparam logic [1:0] WdSi    = 2'd2;

  // sequencing conditions
  localparam logic [2:0] CondNext     = 3'd0;
  localparam logic [2:0] CondGoto     = 3'd1;
  localparam logic [2:0] CondDispatch = 3'd2;
  localparam logic [2:0] CondLoopN    = 3'd3;
  localparam logic [2:0] CondKsa      = 3'd4;
  localparam logic [2:0] CondOutFree  = 3'd5;

  // program steps
  localparam logic [StepW-1:0] StepIdle   = 4'd0;
  localparam logic [StepW-1:0] StepInit   = 4'd1;
  localparam logic [StepW-1:0] StepKsaChk = 4'd2;
  localparam logic [StepW-1:0] StepK0     = 4'd3;
  localparam logic [StepW-1:0] StepK1     = 4'd4;
  localparam logic [StepW-1:0] StepK2     = 4'd5;
  localparam logic [StepW-1:0] StepK3     = 4'd6;
  localparam logic [StepW-1:0] StepKEnd   = 4'd7;
  localparam logic [StepW-1:0] StepD0     = 4'd8;
  localparam logic [StepW-1:0] StepD1     = 4'd9;
  localparam logic [StepW-1:0] StepD2     = 4'd10;
  localparam logic [StepW-1:0] StepD3     = 4'd11;
  localparam logic [StepW-1:0] StepD4     = 4'd12;
  localparam logic [StepW-1:0] StepD5     = 4'd13;

  typedef struct packed {
    logic [1:0]       mem_op;
    logic [2:0]       addr_sel;
    logic [1:0]       wdata_sel;
    logic             key_rd;
    logic             use_key;
    logic             ld_si;
    logic             ld_sj;
    logic             ld_j;
    logic             n_inc;
    logic             kidx_inc;
    logic             clr_idx;
    logic             out_ld;
    logic [2:0]       cond;
    logic [StepW-1:0] target;
  } rc4_ctrl_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } rc4_stat_t;

  function automatic rc4_ctrl_t ucode_rom(input logic [StepW-1:0] step);
    rc4_ctrl_t w;
    w = '0;
    case (step)
      StepIdle: begin
        w.cond = CondDispatch;
      end
      // identity fill, also the clearing pass after reset
      StepInit: begin
        w.mem_op    = MemWr;
        w.addr_sel  = AddrN;
        w.wdata_sel = WdN;
        w.n_inc     = 1'b1;
        w.cond      = CondLoopN;
        w.target    = StepInit;
      end
      StepKsaChk: begin
        w.cond   = CondKsa;
        w.target = StepIdle;
      end
      StepK0: begin
        w.mem_op   = MemRd;
        w.addr_sel = AddrN;
        w.key_rd   = 1'b1;
        w.cond     = CondNext;
      end
      StepK1: begin
        w.mem_op   = MemRd;
        w.addr_sel = AddrJNext;
        w.use_key  = 1'b1;
        w.ld_si    = 1'b1;
        w.ld_j     = 1'b1;
        w.cond     = CondNext;
      end
      StepK2: begin
        w.mem_op    = MemWr;
        w.addr_sel  = AddrN;
        w.wdata_sel = WdRdata;
        w.cond      = CondNext;
      end
      StepK3: begin
        w.mem_op    = MemWr;
        w.addr_sel  = AddrJ;
        w.wdata_sel = WdSi;
        w.n_inc     = 1'b1;
        w.kidx_inc  = 1'b1;
        w.cond      = CondLoopN;
        w.target    = StepK0;
      end
      StepKEnd: begin
        w.clr_idx = 1'b1;
        w.cond    = CondGoto;
        w.target  = StepIdle;
      end
      StepD0: begin
        w.mem_op   = MemRd;
        w.addr_sel = AddrI;
        w.cond     = CondNext;
      end
      StepD1: begin
        w.mem_op   = MemRd;
        w.addr_sel = AddrJNext;
        w.ld_si    = 1'b1;
        w.ld_j     = 1'b1;
        w.cond     = CondNext;
      end
      StepD2: begin
        w.mem_op    = MemWr;
        w.addr_sel  = AddrI;
        w.wdata_sel = WdRdata;
        w.ld_sj     = 1'b1;
        w.cond      = CondNext;
      end
      StepD3: begin
        w.mem_op    = MemWr;
        w.addr_sel  = AddrJ;
        w.wdata_sel = WdSi;
        w.cond      = CondNext;
      end
      StepD4: begin
        w.mem_op   = MemRd;
        w.addr_sel = AddrSum;
        w.cond     = CondNext;
      end
      StepD5: begin
        w.out_ld = 1'b1;
        w.cond   = CondOutFree;
        w.target = StepIdle;
      end
      default: begin
        w.cond   = CondGoto;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/rc4_ucode_seq.sv -----
// ----------------------------------------------------------------------------
// rc4_ucode_seq
// Step counter and program rom; issues one control word per cycle.
// ----------------------------------------------------------------------------
module rc4_ucode_seq
  import rc4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      req_type_i,
  input  logic      last_key_i,
  input  rc4_stat_t stat_i,
  output logic      in_stall_o,
  output rc4_ctrl_t ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             ksa_q, ksa_d;
  logic             accept;

  assign ctrl_o     = ucode_rom(step_q);
  assign in_stall_o = (step_q != StepIdle);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    step_d = step_q + 4'd1;
    ksa_d  = ksa_q;
    case (ctrl_o.cond)
      CondNext: begin
        step_d = step_q + 4'd1;
      end
      CondGoto: begin
        step_d = ctrl_o.target;
      end
      CondDispatch: begin
        step_d = StepIdle;
        if (accept) begin
          if (req_type_i == ReqData) begin
            step_d = StepD0;
          end else if (last_key_i) begin
            step_d = StepInit;
            ksa_d  = 1'b1;
          end
        end
      end
      CondLoopN: begin
        step_d = stat_i.n_last ? step_q + 4'd1 : ctrl_o.target;
      end
      // fall through to the schedule only when a key load asked for it
      CondKsa: begin
        step_d = ksa_q ? step_q + 4'd1 : ctrl_o.target;
        ksa_d  = 1'b0;
      end
      CondOutFree: begin
        step_d = stat_i.out_free ? ctrl_o.target : step_q;
      end
      default: begin
        step_d = StepIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepInit;
      ksa_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      ksa_q  <= ksa_d;
    end
  end

endmodule

// ----- rtl/rc4_datapath.sv -----
// ----------------------------------------------------------------------------
// rc4_datapath
// S-box and key memories, index registers and output register.
// ----------------------------------------------------------------------------
module rc4_datapath
  import rc4_pkg::*;
#(
  parameter int unsigned MaxKeyLen = MaxKeyLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rc4_ctrl_t        ctrl_i,
  input  logic             in_accept_i,
  input  logic             req_type_i,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             last_key_i,
  input  logic             start_message_i,
  input  logic             out_stall_i,
  output rc4_stat_t        stat_o,
  output logic             out_valid_o,
  output logic [ByteW-1:0] byte_out_o
);

  logic [ByteW-1:0]   sbox_mem [SboxDepth];
  logic [ByteW-1:0]   key_mem  [KeyDepth];

  logic [ByteW-1:0]   rdata_q, krdata_q;
  logic [ByteW-1:0]   si_q, sj_q, byte_q;
  logic [ByteW-1:0]   i_q, j_q, n_q, kidx_q;
  logic [KeyLenW-1:0] key_len_q;
  logic               out_valid_q;
  logic [ByteW-1:0]   byte_out_q;

  logic [ByteW-1:0]   j_next, addr, wdata;
  logic               key_acc, data_acc, key_we, kidx_wrap, out_free;

  assign key_acc   = in_accept_i & (req_type_i == ReqKey);
  assign data_acc  = in_accept_i & (req_type_i == ReqData);
  assign key_we    = key_acc & (key_len_q < KeyLenW'(MaxKeyLen));
  assign j_next    = j_q + rdata_q + (ctrl_i.use_key ? krdata_q : 8'd0);
  assign kidx_wrap = (({1'b0, kidx_q} + 9'd1) == key_len_q);
  assign out_free  = ~out_valid_q | ~out_stall_i;

  assign stat_o.n_last   = (n_q == 8'hFF);
  assign stat_o.out_free = out_free;

  always_comb begin
    case (ctrl_i.addr_sel)
      AddrN:     addr = n_q;
      AddrI:     addr = i_q;
      AddrJ:     addr = j_q;
      AddrJNext: addr = j_next;
      AddrSum:   addr = si_q + sj_q;
      default:   addr = n_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.wdata_sel)
      WdN:     wdata = n_q;
      WdRdata: wdata = rdata_q;
      WdSi:    wdata = si_q;
      default: wdata = n_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_op == MemWr) begin
      sbox_mem[addr] <= wdata;
    end
    if (ctrl_i.mem_op == MemRd) begin
      rdata_q <= sbox_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_len_q[ByteW-1:0]] <= byte_in_i;
    end
    if (ctrl_i.key_rd) begin
      krdata_q <= key_mem[kidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_si) begin
      si_q <= rdata_q;
    end
    if (ctrl_i.ld_sj) begin
      sj_q <= rdata_q;
    end
    if (data_acc) begin
      byte_q <= byte_in_i;
    end
    if (ctrl_i.out_ld && out_free) begin
      byte_out_q <= byte_q ^ rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
      key_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (key_we) begin
        key_len_q <= key_len_q + 9'd1;
      end
      // schedule starts from j = 0 and the first key byte
      if (key_acc && last_key_i) begin
        j_q    <= '0;
        kidx_q <= '0;
      end
      if (data_acc) begin
        i_q <= start_message_i ? 8'd1 : i_q + 8'd1;
        j_q <= start_message_i ? 8'd0 : j_q;
      end
      if (ctrl_i.ld_j) begin
        j_q <= j_next;
      end
      if (ctrl_i.n_inc) begin
        n_q <= n_q + 8'd1;
      end
      if (ctrl_i.kidx_inc) begin
        kidx_q <= kidx_wrap ? 8'd0 : kidx_q + 8'd1;
      end
      if (ctrl_i.clr_idx) begin
        i_q       <= '0;
        j_q       <= '0;
        key_len_q <= '0;
      end
      if (ctrl_i.out_ld && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_out_q;

endmodule

// ----- rtl/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher driven by a small microcoded sequencer over a single-port
// s-box memory.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   req_type_i byte_in_i
//                                                 last_key_i start_message_i
//   out      result     out_valid_o / out_stall_i byte_out_o
//
// a key byte is taken in the idle step; a data byte is taken there and then
// runs five s-box accesses for the swap and keystream read on one memory port
// and the output load, with no new request taken until the result is loaded.
// a final key byte adds an identity fill of all 256 s-box entries, a check
// step, a round of steps K0 to K3 for each entry and a closing step.
// after reset the s-box is filled with the identity before the first request is
// taken; a stalled result holds the sequencer at its last step.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned MaxKeyLen = MaxKeyLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             req_type_i,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             last_key_i,
  input  logic             start_message_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] byte_out_o
);

  rc4_ctrl_t ctrl;
  rc4_stat_t stat;
  logic      in_accept;

  assign in_accept = in_valid_i & ~in_stall_o;

  rc4_ucode_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .last_key_i (last_key_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  rc4_datapath #(
    .MaxKeyLen (MaxKeyLen)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .in_accept_i     (in_accept),
    .req_type_i      (req_type_i),
    .byte_in_i       (byte_in_i),
    .last_key_i      (last_key_i),
    .start_message_i (start_message_i),
    .out_stall_i     (out_stall_i),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .byte_out_o      (byte_out_o)
  );

endmodule

// ----- test/rc4_stream_cipher_test.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_test
// Self-checking bench for the RC4 byte cipher. Key and data requests are
// driven with random gaps and result stalls. A scoreboard keeps its own s-box,
// key store and i/j indices, predicts every keystream byte and compares it
// with each accepted result.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_test;
  import rc4_pkg::*;

  localparam int unsigned ItemTarget = 750;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned TailCycles = 1400;

  class rc4_scoreboard;
    logic [ByteW-1:0] perm [SboxDepth];
    logic [ByteW-1:0] key_bytes [KeyDepth];
    int unsigned      key_count;
    logic [ByteW-1:0] idx_i;
    logic [ByteW-1:0] idx_j;
    logic [ByteW-1:0] pending_bytes [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      rekeys;
    int unsigned      dropped;

    function new();
      load_identity();
      key_count = 0;
      idx_i = '0;
      idx_j = '0;
      errors = 0;
      checked = 0;
      rekeys = 0;
      dropped = 0;
    endfunction

    function void load_identity();
      for (int n = 0; n < SboxDepth; n++) begin
        perm[n] = ByteW'(n);
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    function void note_request(logic req, logic [ByteW-1:0] b, logic last, logic start);
      logic [ByteW-1:0] j;
      logic [ByteW-1:0] kb;
      logic [ByteW-1:0] t;
      logic [ByteW-1:0] sum;
      if (req == ReqKey) begin
        if (key_count < MaxKeyLenDef) begin
          key_bytes[key_count] = b;
          key_count++;
        end else begin
          dropped++;
        end
        if (last) begin
          load_identity();
          j = '0;
          for (int n = 0; n < SboxDepth; n++) begin
            kb = (key_count != 0) ? key_bytes[n % key_count] : '0;
            j = j + perm[n] + kb;
            t = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
          end
          key_count = 0;
          idx_i = '0;
          idx_j = '0;
          rekeys++;
        end
      end else begin
        if (start) begin
          idx_i = '0;
          idx_j = '0;
        end
        idx_i = idx_i + 1'b1;
        idx_j = idx_j + perm[idx_i];
        t = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        sum = perm[idx_i] + perm[idx_j];
        pending_bytes = {pending_bytes, b ^ perm[sum]};
      end
    endfunction

    function void check_result(logic [ByteW-1:0] got);
      logic [ByteW-1:0] want;
      if (pending_bytes.size() == 0) begin
        $error("byte_out: result with no request waiting, actual %02h", got);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        checked++;
        if (got !== want) begin
          $error("byte_out: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             req_type_i;
  logic [ByteW-1:0] byte_in_i;
  logic             last_key_i;
  logic             start_message_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ByteW-1:0] byte_out_o;

  rc4_scoreboard board;
  bit            steady;
  int unsigned   sent;
  int unsigned   cycles = 0;

  rc4_stream_cipher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .byte_in_i       (byte_in_i),
    .last_key_i      (last_key_i),
    .start_message_i (start_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_out_o      (byte_out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, none during the steady stretch
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(byte_out_o);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic req, input logic [ByteW-1:0] b,
                              input logic last, input logic start);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    byte_in_i       <= b;
    last_key_i      <= last;
    start_message_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(req, b, last, start);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_request(ReqKey, ByteW'($urandom_range(255)), k == len - 1,
                   $urandom_range(7) == 0);
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned pick;
    bit          long_key_done;
    bit          paused;
    board = new();
    long_key_done = 1'b0;
    paused = 1'b0;
    sent = 0;
    steady = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = ReqKey;
    byte_in_i = '0;
    last_key_i = 1'b0;
    start_message_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity s-box before any key, last_key on data is ignored
    send_request(ReqData, 8'h00, 1'b0, 1'b1);
    send_request(ReqData, 8'hFF, 1'b0, 1'b0);
    send_request(ReqData, 8'h5A, 1'b1, 1'b0);
    // one zero key byte
    send_request(ReqKey, 8'h00, 1'b1, 1'b0);
    send_request(ReqData, 8'hFF, 1'b0, 1'b1);
    send_request(ReqData, 8'h00, 1'b0, 1'b0);
    drain_results();
    // start_message on key requests is ignored
    send_request(ReqKey, 8'hFF, 1'b0, 1'b1);
    send_request(ReqKey, 8'h80, 1'b0, 1'b0);
    send_request(ReqKey, 8'h01, 1'b1, 1'b1);
    // data straight after a schedule with no start mark
    send_request(ReqData, 8'hA5, 1'b0, 1'b0);
    send_request(ReqData, 8'h3C, 1'b1, 1'b0);
    send_request(ReqData, 8'hC3, 1'b0, 1'b1);
    send_request(ReqData, 8'h7E, 1'b0, 1'b0);
    send_request(ReqKey, 8'h7F, 1'b1, 1'b0);
    send_request(ReqData, 8'h81, 1'b0, 1'b1);
    send_request(ReqData, 8'h18, 1'b0, 1'b0);

    while (sent < ItemTarget) begin
      steady = (sent >= 330 && sent < 480);
      pick = $urandom_range(99);
      if (!long_key_done && sent >= 200) begin
        // fills the key store, the marked byte itself is dropped
        send_key($urandom_range(258, 272));
        long_key_done = 1'b1;
      end else if (!paused && sent >= 420) begin
        drain_results();
        paused = 1'b1;
      end else if (pick < 72) begin
        if ($urandom_range(1) == 1) begin
          send_key(($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16));
        end
        len = $urandom_range(1, 24);
        for (int unsigned k = 0; k < len; k++) begin
          send_request(ReqData, ByteW'($urandom_range(255)), $urandom_range(7) == 0,
                       k == 0 || $urandom_range(15) == 0);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++) begin
          send_request(1'($urandom_range(1)), ByteW'($urandom_range(255)),
                       $urandom_range(3) == 0, 1'($urandom_range(1)));
        end
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d key schedules, %0d key bytes dropped on overflow",
             sent, board.rekeys, board.dropped);
    $display("checked %0d cipher bytes under random gaps and result stalls", board.checked);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
